// ===== hw/rtl/jst_pkg.sv =====
package jst_pkg;

  localparam int MaxDepth = 32;
  localparam int DepthW = $clog2(MaxDepth + 1);
  localparam int PtrW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  localparam logic [4:0] M_START      = 5'd0;
  localparam logic [4:0] M_VALUE      = 5'd1;
  localparam logic [4:0] M_ARR_FIRST  = 5'd2;
  localparam logic [4:0] M_OBJ_FIRST  = 5'd3;
  localparam logic [4:0] M_KEY        = 5'd4;
  localparam logic [4:0] M_KEY_CHARS  = 5'd5;
  localparam logic [4:0] M_COLON      = 5'd6;
  localparam logic [4:0] M_STR        = 5'd7;
  localparam logic [4:0] M_LIT        = 5'd8;
  localparam logic [4:0] M_NUM_SIGN   = 5'd9;
  localparam logic [4:0] M_NUM_DIGITS = 5'd10;
  localparam logic [4:0] M_NUM_ZERO   = 5'd11;
  localparam logic [4:0] M_AFTER      = 5'd12;

  localparam logic [4:0] EV_NONE      = 5'd0;
  localparam logic [4:0] EV_OBJ_OPEN  = 5'd1;
  localparam logic [4:0] EV_OBJ_CLOSE = 5'd2;
  localparam logic [4:0] EV_ARR_OPEN  = 5'd3;
  localparam logic [4:0] EV_ARR_CLOSE = 5'd4;
  localparam logic [4:0] EV_KEY_OPEN  = 5'd5;
  localparam logic [4:0] EV_KEY_CHAR  = 5'd6;
  localparam logic [4:0] EV_KEY_CLOSE = 5'd7;
  localparam logic [4:0] EV_STR_OPEN  = 5'd8;
  localparam logic [4:0] EV_STR_CHAR  = 5'd9;
  localparam logic [4:0] EV_STR_CLOSE = 5'd10;
  localparam logic [4:0] EV_LIT_BYTE  = 5'd11;
  localparam logic [4:0] EV_TRUE      = 5'd12;
  localparam logic [4:0] EV_NUM_BYTE  = 5'd15;
  localparam logic [4:0] EV_COLON     = 5'd16;
  localparam logic [4:0] EV_COMMA     = 5'd17;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_START    = 3'd1;
  localparam logic [2:0] ERR_CHAR     = 3'd2;
  localparam logic [2:0] ERR_DIGIT    = 3'd3;
  localparam logic [2:0] ERR_TRAIL    = 3'd4;
  localparam logic [2:0] ERR_EARLY    = 3'd5;
  localparam logic [2:0] ERR_DEEP     = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW = 3'd7;

  localparam logic [0:0] REG_DEPTH_LIMIT = 1'd0;

  typedef enum logic [1:0] {
    STK_NONE = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2,
    STK_CLR  = 2'd3
  } stk_op_e;

  // shift-chain control: all cells see the same op each cycle
  typedef struct packed {
    stk_op_e    op;
    logic       kind;
  } stk_ctl_t;

  typedef struct packed {
    logic [4:0]  event_res;
    logic [7:0]  char_out;
    logic        number_done;
    logic [63:0] number_value;
    logic [5:0]  depth;
    logic [2:0]  error_code;
    logic        accepted;
    logic [31:0] line;
    logic [31:0] column;
  } out_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] s);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (s)
          3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (s)
          3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (s)
          3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage

// ===== hw/rtl/jst_if.sv =====
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;
  modport source (output valid, byte_in, last_byte, input ready);
  modport sink (input valid, byte_in, last_byte, output ready);
endinterface

interface jst_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  event_res;
  logic [7:0]  char_out;
  logic        number_done;
  logic [63:0] number_value;
  logic [5:0]  depth;
  logic [2:0]  error_code;
  logic        accepted;
  logic [31:0] line;
  logic [31:0] column;
  modport source (output valid, event_res, char_out, number_done, number_value, depth,
                  error_code, accepted, line, column, input ready);
  modport sink (input valid, event_res, char_out, number_done, number_value, depth,
                error_code, accepted, line, column, output ready);
endinterface

// ===== hw/rtl/jst_cell.sv =====
// One stack entry; push shifts kinds down the chain, pop shifts them up.
module jst_cell
  import jst_pkg::*;
(
  input  logic     clk_i,
  input  stk_ctl_t ctl_i,
  input  logic     up_i,
  input  logic     down_i,
  output logic     kind_o
);
  logic kind_q, kind_d;

  always_comb begin
    unique case (ctl_i.op)
      STK_PUSH: kind_d = up_i;
      STK_POP:  kind_d = down_i;
      STK_NONE: kind_d = kind_q;
      STK_CLR:  kind_d = kind_q;
      default:  kind_d = kind_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;
endmodule

// ===== hw/rtl/jst_stack.sv =====
// Cell 0 is the top of stack.
module jst_stack
  import jst_pkg::*;
(
  input  logic     clk_i,
  input  stk_ctl_t ctl_i,
  output logic     top_o
);
  logic [MaxDepth-1:0] kind;
  logic [MaxDepth:0]   down;

  assign down[MaxDepth] = 1'b0;

  for (genvar g = 0; g < MaxDepth; g++) begin : g_cell
    assign down[g] = kind[g];
    jst_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .up_i   ((g == 0) ? ctl_i.kind : kind[(g == 0) ? 0 : g-1]),
      .down_i (down[g+1]),
      .kind_o (kind[g])
    );
  end

  assign top_o = kind[0];
endmodule

// ===== hw/rtl/json_stream_tokenizer.sv =====
// Channel  Dir  Payload
// in_if    in   byte_in[7:0], last_byte
// out_if   out  event_res, char_out, number_done, number_value, depth,
//              error_code, accepted, line, column
// APB      in   depth_limit at address 0
// One byte per cycle unless the output stalls; each byte's result is registered in the output register.
// The nesting stack is a shifting chain of cells, pushed and popped only on accepted brackets.
// rst_ni clears the parse state and sets depth_limit to 32.
// A stalled output holds; a new byte is taken when the output is empty or is being taken.
module json_stream_tokenizer
  import jst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  jst_in_if.sink      in_if,
  jst_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [63:0] OvfLim = 64'd922337203685477580;

  logic [5:0]        limit_q;
  logic [4:0]        mode_q, mode_d;
  logic [2:0]        step_q, step_d;
  logic [1:0]        kind_q, kind_d;
  logic [DepthW-1:0] dep_q, dep_d;
  logic [63:0]       acc_q, acc_d;
  logic              neg_q, neg_d;
  logic [31:0]       line_q, line_d, col_q, col_d;
  logic [2:0]        err_q, err_d;
  logic              ovalid_q;
  out_t              out_q, res;
  stk_ctl_t          sctl;
  logic              top;
  logic              take;

  assign pready = 1'b1;
  assign prdata = {26'd0, limit_q};
  assign in_if.ready = !ovalid_q || out_if.ready;
  assign take = in_if.valid && in_if.ready;

  jst_stack u_stack (.clk_i(clk_i), .ctl_i(sctl), .top_o(top));

  always_comb begin
    logic [7:0]  b;
    logic        ws, isd, done, pushk, dopush, dopop, after;
    logic [4:0]  ev;
    logic [7:0]  ch;
    logic [63:0] val;
    logic [5:0]  lim;
    logic [3:0]  d;
    b = in_if.byte_in;
    ws = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    isd = (b >= "0") && (b <= "9");
    d = 4'(b - "0");
    ev = EV_NONE; ch = 8'h00; done = 1'b0; val = 64'd0;
    mode_d = mode_q; step_d = step_q; kind_d = kind_q; dep_d = dep_q;
    acc_d = acc_q; neg_d = neg_q; line_d = line_q; col_d = col_q; err_d = err_q;
    dopush = 1'b0; dopop = 1'b0; pushk = 1'b0; after = 1'b0;
    lim = (limit_q == 6'd0) ? 6'd1 : (limit_q > 6'(MaxDepth)) ? 6'(MaxDepth) : limit_q;
    if (err_q == ERR_NONE) begin
      if (b == 8'h0a) begin
        if (line_q != '1) line_d = line_q + 32'd1;
        col_d = '0;
      end else if (col_q != '1) begin
        col_d = col_q + 32'd1;
      end
      unique case (mode_q)
        M_START, M_VALUE, M_ARR_FIRST: begin
          if ((mode_q == M_START) || !ws) begin
            if ((mode_q == M_ARR_FIRST) && (b == "]")) after = 1'b1;
            else if (b == "{" || b == "[") begin
              if ({{(7-DepthW){1'b0}}, dep_q} >= {1'b0, lim}) err_d = ERR_DEEP;
              else begin
                pushk = (b == "[");
                dopush = 1'b1;
                dep_d = dep_q + DepthW'(1);
                ev = pushk ? EV_ARR_OPEN : EV_OBJ_OPEN;
                mode_d = pushk ? M_ARR_FIRST : M_OBJ_FIRST;
              end
            end else if (b == "\"") begin
              ev = EV_STR_OPEN; mode_d = M_STR;
            end else if (b == "t" || b == "f" || b == "n") begin
              kind_d = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
              step_d = 3'd1; ev = EV_LIT_BYTE; mode_d = M_LIT;
            end else begin
              acc_d = '0; neg_d = 1'b0;
              if (b == "-") begin neg_d = 1'b1; ev = EV_NUM_BYTE; mode_d = M_NUM_SIGN; end
              else if (b == "0") begin ev = EV_NUM_BYTE; mode_d = M_NUM_ZERO; end
              else if (isd) begin
                acc_d = {60'd0, d}; ev = EV_NUM_BYTE; mode_d = M_NUM_DIGITS;
              end else err_d = ERR_START;
            end
          end
        end
        M_OBJ_FIRST, M_KEY: begin
          if (!ws) begin
            if ((mode_q == M_OBJ_FIRST) && (b == "}")) after = 1'b1;
            else if (b == "\"") begin ev = EV_KEY_OPEN; mode_d = M_KEY_CHARS; end
            else err_d = ERR_CHAR;
          end
        end
        M_KEY_CHARS: begin
          if (b == "\"") begin ev = EV_KEY_CLOSE; mode_d = M_COLON; end
          else begin ev = EV_KEY_CHAR; ch = b; end
        end
        M_COLON: begin
          if (!ws) begin
            if (b == ":") begin ev = EV_COLON; mode_d = M_VALUE; end
            else err_d = ERR_CHAR;
          end
        end
        M_STR: begin
          if (b == "\"") begin ev = EV_STR_CLOSE; mode_d = M_AFTER; end
          else begin ev = EV_STR_CHAR; ch = b; end
        end
        M_LIT: begin
          if (step_q >= lit_len(kind_q) || b != lit_char(kind_q, step_q)) err_d = ERR_CHAR;
          else begin
            step_d = step_q + 3'd1;
            if (step_d == lit_len(kind_q)) begin
              ev = EV_TRUE + {3'd0, kind_q}; mode_d = M_AFTER;
            end else ev = EV_LIT_BYTE;
          end
        end
        M_NUM_SIGN: begin
          if (b == "0") begin ev = EV_NUM_BYTE; mode_d = M_NUM_ZERO; end
          else if (isd) begin
            acc_d = {60'd0, d}; ev = EV_NUM_BYTE; mode_d = M_NUM_DIGITS;
          end else err_d = ERR_DIGIT;
        end
        M_NUM_DIGITS, M_NUM_ZERO: begin
          if ((mode_q == M_NUM_DIGITS) && isd) begin
            if (acc_q > OvfLim || (acc_q == OvfLim && d > 4'd7)) err_d = ERR_OVERFLOW;
            else begin
              acc_d = (acc_q << 3) + (acc_q << 1) + {60'd0, d};
              ev = EV_NUM_BYTE;
            end
          end else begin
            done = 1'b1; val = neg_q ? -acc_q : acc_q; mode_d = M_AFTER; after = 1'b1;
          end
        end
        M_AFTER: after = 1'b1;
        default: err_d = ERR_CHAR;
      endcase
      if (after && !ws) begin
        if (dep_q == '0) err_d = ERR_TRAIL;
        else if (b == ",") begin
          ev = EV_COMMA; mode_d = top ? M_VALUE : M_KEY;
        end else if ((!top && b == "}") || (top && b == "]")) begin
          dopop = 1'b1; dep_d = dep_q - DepthW'(1);
          ev = top ? EV_ARR_CLOSE : EV_OBJ_CLOSE; mode_d = M_AFTER;
        end else err_d = ERR_CHAR;
      end
      if (err_d != ERR_NONE) begin
        ev = EV_NONE; ch = 8'h00; done = 1'b0; val = '0; dopush = 1'b0; dopop = 1'b0;
        dep_d = dep_q;
      end
    end
    res.accepted = 1'b0;
    if (in_if.last_byte) begin
      if (err_d == ERR_NONE) begin
        if (mode_d == M_NUM_DIGITS || mode_d == M_NUM_ZERO) begin
          done = 1'b1; val = neg_d ? -acc_d : acc_d; mode_d = M_AFTER;
        end else if (mode_d == M_NUM_SIGN) err_d = ERR_DIGIT;
        if (err_d == ERR_NONE && !(mode_d == M_AFTER && dep_d == '0)) err_d = ERR_EARLY;
        if (err_d != ERR_NONE) begin ev = EV_NONE; ch = 8'h00; done = 1'b0; val = '0; end
      end
      res.accepted = (err_d == ERR_NONE);
    end
    res.event_res = ev; res.char_out = ch; res.number_done = done; res.number_value = val;
    res.depth = 6'(dep_d); res.error_code = err_d; res.line = line_d; res.column = col_d;
    sctl.kind = pushk;
    sctl.op = !take ? STK_NONE : dopush ? STK_PUSH : dopop ? STK_POP : STK_NONE;
    if (in_if.last_byte) begin
      mode_d = M_START; step_d = '0; kind_d = '0; dep_d = '0; acc_d = '0; neg_d = 1'b0;
      line_d = 32'd1; col_d = '0; err_d = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd32; mode_q <= M_START; step_q <= '0; kind_q <= '0; dep_q <= '0;
      acc_q <= '0; neg_q <= 1'b0; line_q <= 32'd1; col_q <= '0; err_q <= ERR_NONE;
      ovalid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == {REG_DEPTH_LIMIT, 1'b0})
        limit_q <= pwdata[5:0];
      if (take) begin
        mode_q <= mode_d; step_q <= step_d; kind_q <= kind_d; dep_q <= dep_d;
        acc_q <= acc_d; neg_q <= neg_d; line_q <= line_d; col_q <= col_d; err_q <= err_d;
      end
      if (in_if.ready) ovalid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= res;
  end

  assign out_if.valid = ovalid_q;
  assign out_if.event_res = out_q.event_res;
  assign out_if.char_out = out_q.char_out;
  assign out_if.number_done = out_q.number_done;
  assign out_if.number_value = out_q.number_value;
  assign out_if.depth = out_q.depth;
  assign out_if.error_code = out_q.error_code;
  assign out_if.accepted = out_q.accepted;
  assign out_if.line = out_q.line;
  assign out_if.column = out_q.column;

  a_depth_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(7-DepthW){1'b0}}, dep_q} <= 7'(MaxDepth)) else $error("depth above max");
  a_ev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.error_code != ERR_NONE |-> out_if.event_res == EV_NONE)
    else $error("event with error");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.number_value))
    else $error("output dropped");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.accepted |-> out_if.depth == 6'd0) else $error("accept deep");
endmodule

// ===== bench/testbench.sv =====
module testbench;
  import jst_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int ByteTarget = 1350;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [63:0] AccumCap = 64'd922337203685477580;

  class token_scoreboard;
    out_t        exp_q[$];
    int          mism;
    int          checked;
    int          docs_ok;
    int          docs_bad;
    logic [5:0]  lim_reg;
    logic [4:0]  mode;
    logic [2:0]  lit_step;
    logic [1:0]  lit_kind;
    bit          nest_kind[MaxDepth];
    int          nest;
    logic [63:0] accum;
    bit          neg;
    logic [31:0] line_cnt;
    logic [31:0] col_cnt;
    logic [2:0]  err;
    logic [4:0]  ev;
    logic [7:0]  ch;

    function new();
      lim_reg = 6'd32;
      clear_doc();
    endfunction

    function void clear_doc();
      mode = M_START;
      lit_step = '0;
      lit_kind = '0;
      foreach (nest_kind[i]) nest_kind[i] = 1'b0;
      nest = 0;
      accum = '0;
      neg = 1'b0;
      line_cnt = 32'd1;
      col_cnt = '0;
      err = ERR_NONE;
    endfunction

    function void set_limit(logic [31:0] v);
      lim_reg = v[5:0];
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function bit is_ws(logic [7:0] b);
      return b == ChSp || b == ChTab || b == ChCr || b == ChLf;
    endfunction

    function void fail(logic [2:0] code);
      err = code;
      ev = EV_NONE;
    endfunction

    function void open_nest(bit arr);
      int lim;
      lim = (lim_reg < 1) ? 1 : (lim_reg > MaxDepth) ? MaxDepth : int'(lim_reg);
      if (nest >= lim) begin
        fail(ERR_DEEP);
        return;
      end
      nest_kind[nest] = arr;
      nest++;
      ev = arr ? EV_ARR_OPEN : EV_OBJ_OPEN;
      mode = arr ? M_ARR_FIRST : M_OBJ_FIRST;
    endfunction

    function void begin_value(logic [7:0] b);
      if (b == "{") begin
        open_nest(1'b0);
      end else if (b == "[") begin
        open_nest(1'b1);
      end else if (b == "\"") begin
        ev = EV_STR_OPEN;
        mode = M_STR;
      end else if (b == "t" || b == "f" || b == "n") begin
        lit_kind = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
        lit_step = 3'd1;
        ev = EV_LIT_BYTE;
        mode = M_LIT;
      end else begin
        accum = '0;
        neg = 1'b0;
        if (b == "-") begin
          neg = 1'b1;
          ev = EV_NUM_BYTE;
          mode = M_NUM_SIGN;
        end else if (b == "0") begin
          ev = EV_NUM_BYTE;
          mode = M_NUM_ZERO;
        end else if (b >= "1" && b <= "9") begin
          accum = 64'(b - "0");
          ev = EV_NUM_BYTE;
          mode = M_NUM_DIGITS;
        end else begin
          fail(ERR_START);
        end
      end
    endfunction

    function void close_or_sep(logic [7:0] b);
      bit arr;
      if (is_ws(b)) return;
      if (nest == 0) begin
        fail(ERR_TRAIL);
        return;
      end
      arr = nest_kind[(nest - 1) % MaxDepth];
      if (b == ",") begin
        ev = EV_COMMA;
        mode = arr ? M_VALUE : M_KEY;
      end else if ((!arr && b == "}") || (arr && b == "]")) begin
        nest--;
        ev = arr ? EV_ARR_CLOSE : EV_OBJ_CLOSE;
        mode = M_AFTER;
      end else begin
        fail(ERR_CHAR);
      end
    endfunction

    function logic [63:0] signed_accum();
      return neg ? (64'd0 - accum) : accum;
    endfunction

    function void advance(logic [7:0] b, ref bit done, ref logic [63:0] val);
      string words[3];
      int k;
      int s;
      words = '{"true", "false", "null"};
      case (mode)
        M_START: begin
          begin_value(b);
        end
        M_VALUE: begin
          if (!is_ws(b)) begin_value(b);
        end
        M_ARR_FIRST: begin
          if (!is_ws(b)) begin
            if (b == "]") close_or_sep(b);
            else begin_value(b);
          end
        end
        M_OBJ_FIRST, M_KEY: begin
          if (!is_ws(b)) begin
            if (mode == M_OBJ_FIRST && b == "}") begin
              close_or_sep(b);
            end else if (b == "\"") begin
              ev = EV_KEY_OPEN;
              mode = M_KEY_CHARS;
            end else begin
              fail(ERR_CHAR);
            end
          end
        end
        M_KEY_CHARS: begin
          if (b == "\"") begin
            ev = EV_KEY_CLOSE;
            mode = M_COLON;
          end else begin
            ev = EV_KEY_CHAR;
            ch = b;
          end
        end
        M_COLON: begin
          if (!is_ws(b)) begin
            if (b == ":") begin
              ev = EV_COLON;
              mode = M_VALUE;
            end else begin
              fail(ERR_CHAR);
            end
          end
        end
        M_STR: begin
          if (b == "\"") begin
            ev = EV_STR_CLOSE;
            mode = M_AFTER;
          end else begin
            ev = EV_STR_CHAR;
            ch = b;
          end
        end
        M_LIT: begin
          k = lit_kind % 3;
          s = lit_step % 6;
          if (s >= words[k].len() || b != words[k][s]) begin
            fail(ERR_CHAR);
          end else begin
            lit_step = 3'(s + 1);
            if (s + 1 == words[k].len()) begin
              ev = EV_TRUE + 5'(k);
              mode = M_AFTER;
            end else begin
              ev = EV_LIT_BYTE;
            end
          end
        end
        M_NUM_SIGN: begin
          if (b == "0") begin
            ev = EV_NUM_BYTE;
            mode = M_NUM_ZERO;
          end else if (b >= "1" && b <= "9") begin
            accum = 64'(b - "0");
            ev = EV_NUM_BYTE;
            mode = M_NUM_DIGITS;
          end else begin
            fail(ERR_DIGIT);
          end
        end
        M_NUM_DIGITS: begin
          if (b >= "0" && b <= "9") begin
            if (accum > AccumCap || (accum == AccumCap && (b - "0") > 7)) begin
              fail(ERR_OVERFLOW);
            end else begin
              accum = accum * 10 + 64'(b - "0");
              ev = EV_NUM_BYTE;
            end
          end else begin
            done = 1'b1;
            val = signed_accum();
            mode = M_AFTER;
            close_or_sep(b);
          end
        end
        M_NUM_ZERO: begin
          done = 1'b1;
          val = signed_accum();
          mode = M_AFTER;
          close_or_sep(b);
        end
        M_AFTER: begin
          close_or_sep(b);
        end
        default: begin
          fail(ERR_CHAR);
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      out_t e;
      bit done;
      logic [63:0] val;
      done = 1'b0;
      val = '0;
      ev = EV_NONE;
      ch = '0;
      if (err == ERR_NONE) begin
        if (b == ChLf) begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = '0;
        end else if (col_cnt != '1) begin
          col_cnt++;
        end
        advance(b, done, val);
        if (err != ERR_NONE) begin
          done = 1'b0;
          val = '0;
          ch = '0;
        end
      end
      e.accepted = 1'b0;
      if (last) begin
        if (err == ERR_NONE) begin
          if (mode == M_NUM_DIGITS || mode == M_NUM_ZERO) begin
            done = 1'b1;
            val = signed_accum();
            mode = M_AFTER;
          end else if (mode == M_NUM_SIGN) begin
            err = ERR_DIGIT;
          end
          if (err == ERR_NONE && !(mode == M_AFTER && nest == 0)) err = ERR_EARLY;
          if (err != ERR_NONE) begin
            ev = EV_NONE;
            ch = '0;
            done = 1'b0;
            val = '0;
          end
        end
        e.accepted = (err == ERR_NONE);
        if (e.accepted) docs_ok++;
        else docs_bad++;
      end
      e.event_res = ev;
      e.char_out = ch;
      e.number_done = done;
      e.number_value = val;
      e.depth = 6'(nest);
      e.error_code = err;
      e.line = line_cnt;
      e.column = col_cnt;
      exp_q.push_back(e);
      if (last) clear_doc();
    endfunction

    function void check_event(out_t got);
      out_t e;
      if (exp_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("ERROR: unexpected token event %p", got);
        return;
      end
      e = exp_q.pop_front();
      checked++;
      if (got.event_res !== e.event_res || got.char_out !== e.char_out ||
          got.number_done !== e.number_done || got.number_value !== e.number_value ||
          got.depth !== e.depth || got.error_code !== e.error_code ||
          got.accepted !== e.accepted || got.line !== e.line || got.column !== e.column) begin
        mism++;
        if (mism <= 10) begin
          $display("ERROR: token event %0d mismatch", checked);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  jst_in_if  in_if();
  jst_out_if out_if();

  json_stream_tokenizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if.sink),
    .out_if  (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  token_scoreboard sb = new();
  logic [7:0] doc[$];
  int  bytes_sent;
  int  cycles;
  int  hold_cnt;
  bit  tx_calm;
  bit  rx_calm;

  initial begin
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.event_res = out_if.event_res;
      got.char_out = out_if.char_out;
      got.number_done = out_if.number_done;
      got.number_value = out_if.number_value;
      got.depth = out_if.depth;
      got.error_code = out_if.error_code;
      got.accepted = out_if.accepted;
      got.line = out_if.line;
      got.column = out_if.column;
      sb.check_event(got);
    end
  end

  // receiver back-pressure; hold_cnt forces one long stall
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt--;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 9) < 3)
          stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_doc();
    for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
    doc.delete();
  endtask

  task automatic apb_write(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * REG_DEPTH_LIMIT);
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_limit(v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // sender idles until every expected result is out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endfunction

  function automatic void add_ws();
    logic [7:0] ws[4];
    ws = '{ChSp, ChTab, ChCr, ChLf};
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) doc.push_back(ws[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_chars();
    logic [7:0] c;
    repeat ($urandom_range(0, 4)) begin
      c = 8'($urandom_range(0, 255));
      if (c == "\"") c = "a";
      doc.push_back(c);
    end
  endfunction

  function automatic void add_number();
    int n;
    if ($urandom_range(0, 2) == 0) doc.push_back("-");
    if ($urandom_range(0, 5) == 0) begin
      doc.push_back("0");
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
    doc.push_back(8'("1" + $urandom_range(0, 8)));
    repeat (n - 1) doc.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void add_value(int lvl);
    int c;
    int n;
    c = (lvl >= 4) ? $urandom_range(2, 5) : $urandom_range(0, 5);
    case (c)
      0, 1: begin
        doc.push_back(c == 0 ? "{" : "[");
        add_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin
            doc.push_back(",");
            add_ws();
          end
          if (c == 0) begin
            doc.push_back("\"");
            add_chars();
            doc.push_back("\"");
            add_ws();
            doc.push_back(":");
            add_ws();
          end
          add_value(lvl + 1);
          add_ws();
        end
        doc.push_back(c == 0 ? "}" : "]");
      end
      2: begin
        doc.push_back("\"");
        add_chars();
        doc.push_back("\"");
      end
      3: add_text($urandom_range(0, 1) ? "true" : ($urandom_range(0, 1) ? "false" : "null"));
      default: add_number();
    endcase
  endfunction

  // well-formed document with random content, sometimes damaged
  function automatic void make_doc();
    int r;
    add_value(0);
    add_ws();
    r = $urandom_range(0, 19);
    if (r == 0) begin
      doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r == 1 && doc.size() > 1) begin
      repeat ($urandom_range(1, doc.size() - 1)) void'(doc.pop_back());
    end else if (r == 2) begin
      doc.push_back(8'($urandom_range(0, 255)));
    end else if (r == 3) begin
      doc.push_front(ChSp);
    end else if (r == 4) begin
      doc.delete();
      repeat ($urandom_range(1, 6)) doc.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void make_deep(int levels);
    repeat (levels) doc.push_back("[");
    doc.push_back("1");
    repeat (levels) doc.push_back("]");
  endfunction

  initial begin
    string directed[$];
    logic [31:0] limits[$];
    int phase_end;
    directed = '{"[]", "{}", "{\"k\":[true,false,null]}", "-0", "01", "-x", "-", "tru",
                 " 1", "9223372036854775807", "-9223372036854775807",
                 "92233720368547758070", "[1,2}", "[1\n,\t2\r ]", "{\"a\" : \"b\"}",
                 "[", "{1}", "nul!", "[]]"};
    limits = '{32'd1, 32'd0, 32'd63, 32'd5, 32'hFFFF_FFE3, 32'd32};
    hold_cnt = 0;
    bytes_sent = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      add_text(directed[i]);
      send_doc();
    end
    doc = '{"\"", 8'hFF, 8'h00, 8'h7F, "\""};
    send_doc();
    make_deep(32);
    send_doc();
    make_deep(33);
    send_doc();

    for (int p = 0; p <= limits.size(); p++) begin
      drain();
      if (p > 0) apb_write(limits[p - 1]);
      else apb_write(32'd32);
      phase_end = bytes_sent + (ByteTarget - bytes_sent) / (limits.size() + 1 - p);
      make_deep($urandom_range(0, 1) + ((sb.lim_reg == 0) ? 1 :
                (sb.lim_reg > MaxDepth) ? MaxDepth : int'(sb.lim_reg)));
      send_doc();
      if (p == 2) begin
        hold_cnt = 200;
        tx_calm = 1'b1;
        doc.push_back("[");
        repeat (40) add_text("7,");
        doc.push_back("1");
        doc.push_back("]");
        send_doc();
        tx_calm = 1'b0;
      end
      while (bytes_sent < phase_end) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        make_doc();
        send_doc();
      end
    end
    tx_calm = 1'b0;
    in_if.valid <= 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes in %0d documents (%0d accepted, %0d with errors), %0d events checked",
             bytes_sent, sb.docs_ok + sb.docs_bad, sb.docs_ok, sb.docs_bad, sb.checked);
    $display("Depth limits 1..32 incl. clamped writes; %0d mismatches", sb.mism);
    if (sb.mism == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
